// ===== rtl/vrt_pkg.sv =====
package vrt_pkg;
    localparam int GRID_SIDE   = 16;
    localparam int GRID_HEIGHT = 16;
    localparam int MAX_HITS    = 63;
    localparam int XW = $clog2(GRID_SIDE);
    localparam int YW = $clog2(GRID_HEIGHT);
    localparam int ADDR_W = YW + 2 * XW;
    localparam int DEPTH = GRID_SIDE * GRID_HEIGHT * GRID_SIDE;
    localparam int HC_W = 6;
    localparam logic [23:0] T_ALL_ONES = 24'hFFFFFF;

    typedef struct packed {
        logic              mode;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] start_z;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] end_z;
        logic [3:0]         cell_x;
        logic [3:0]         cell_y;
        logic [3:0]         cell_z;
        logic [7:0]         block_value;
    } t_req;

    typedef struct packed {
        logic [3:0] hit_x;
        logic [3:0] hit_y;
        logic [3:0] hit_z;
        logic [7:0] block_code;
        logic       hit_valid;
        logic       last;
        logic       hits_capped;
    } t_rsp;

    // cell index of a q8.8 value, truncated toward zero
    function automatic logic signed [8:0] trunc_cell(input logic signed [15:0] q);
        logic [15:0] m;
        logic [7:0]  c;
        m = q[15] ? 16'(-q) : q;
        c = m[15:8];
        return q[15] ? -$signed({1'b0, c}) : $signed({1'b0, c});
    endfunction
endpackage

// ===== rtl/vrt_if.sv =====
interface vrt_req_if import vrt_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vrt_rsp_if import vrt_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/voxel_ray_traversal.sv =====
// a write is acknowledged with a registered word in the cycle after acceptance
// a ray is set up axis by axis (restoring division, tmax product, saturation; an axis with
// no motion skips division and product); then each in-grid cell is checked, read, visited
// and stepped, a cell outside the grid is checked and stepped, and a terminator word follows
// one item at a time; the input is taken again once the last word is handed over
// synchronous active-low reset clears control state and air_code, then a clearing
// pass over all 4096 voxel entries zeroes the memory before any item is accepted
module voxel_ray_traversal import vrt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    vrt_req_if.sink     req,
    vrt_rsp_if.source   rsp
);
    // controller states
    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_DIV = 4'd2, S_TMAX = 4'd3,
                           S_TMUL = 4'd4, S_CHK = 4'd5, S_RD = 4'd6, S_VIS = 4'd7,
                           S_STEP = 4'd8, S_OUT = 4'd9, S_TERM = 4'd10;

    logic [3:0]  r_state, n_state;
    logic [7:0]  r_air;
    logic [ADDR_W-1:0] r_clr;

    // voxel memory, one write and one registered read port
    logic [7:0]  mem [DEPTH];
    logic [7:0]  r_rd;
    logic        mem_we;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    // ray state; cells can run well past the grid before the length check stops the ray
    logic signed [15:0] r_s [3];
    logic signed [16:0] r_d [3];
    logic signed [11:0] r_cell [3];
    logic signed [11:0] r_endc [3];
    logic [23:0] r_td [3];
    logic [23:0] r_tm [3];
    logic [35:0] r_dist2;
    logic [15:0] r_steps;
    logic [HC_W-1:0] r_hits;
    logic [1:0]  r_ax;
    logic [40:0] r_prod;
    logic        r_capped;
    logic        r_ovalid;
    t_rsp        r_odata;

    // restoring divider for 2^24 / |delta|, one quotient bit a cycle
    logic [24:0] r_quo;
    logic [16:0] r_rem;
    logic [4:0]  r_bit;
    logic [16:0] mag;
    logic [17:0] rem_try;
    logic [16:0] dcur;
    assign dcur = r_d[r_ax];
    assign mag  = dcur[16] ? 17'(-dcur) : dcur;
    assign rem_try = {r_rem, (r_bit == 5'd24)} ;

    // boundary distance for tmax
    logic signed [17:0] f_dist;
    always_comb begin
        if (!dcur[16] && dcur != '0) begin
            f_dist = 18'(($signed({r_cell[r_ax], 8'h00}) + 18'sd256) - r_s[r_ax]);
        end else begin
            f_dist = 18'(r_s[r_ax] - $signed({r_cell[r_ax], 8'h00}));
        end
    end

    // step length check: (k+1)^2 * 2^16 > 9 * dist2
    logic [16:0] k1;
    logic [33:0] k1sq;
    logic [39:0] dist9;
    assign k1    = 17'(r_steps) + 17'd1;
    assign k1sq  = k1 * k1;
    assign dist9 = 40'(r_dist2) * 40'd9;

    logic in_grid, at_end;
    assign in_grid = r_cell[0] >= 0 && r_cell[1] >= 0 && r_cell[2] >= 0 &&
                     r_cell[0] < GRID_SIDE && r_cell[1] < GRID_HEIGHT &&
                     r_cell[2] < GRID_SIDE;
    assign at_end = r_cell[0] == r_endc[0] && r_cell[1] == r_endc[1] &&
                    r_cell[2] == r_endc[2];

    logic [1:0] sel_ax;
    always_comb begin
        if (r_tm[0] < r_tm[1] && r_tm[0] < r_tm[2]) begin
            sel_ax = 2'd0;
        end else if (r_tm[1] < r_tm[2]) begin
            sel_ax = 2'd1;
        end else begin
            sel_ax = 2'd2;
        end
    end

    logic [24:0] tm_sum;
    assign tm_sum = {1'b0, r_tm[sel_ax]} + {1'b0, r_td[sel_ax]};

    assign req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign rsp.valid = r_ovalid;
    assign rsp.data  = r_odata;

    t_req q;
    assign q = req.data;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = '0;
        mem_ra = ADDR_W'({r_cell[1][YW-1:0], r_cell[2][XW-1:0], r_cell[0][XW-1:0]});
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == S_IDLE && req.valid && req.ready && !q.mode) begin
            mem_we = 1'b1;
            mem_wa = ADDR_W'({q.cell_y[YW-1:0], q.cell_z[XW-1:0], q.cell_x[XW-1:0]});
            mem_wd = q.block_value;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: n_state = (r_clr == ADDR_W'(DEPTH - 1)) ? S_IDLE : S_CLEAR;
            default: n_state = r_state;
        endcase
    end

    logic [24:0] sat_t;
    assign sat_t = r_prod[32:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_air    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_air <= i_cfg_wdata;
            end
            if (r_ovalid && rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr   <= r_clr + 1'b1;
                    r_state <= n_state;
                end
                S_IDLE: begin
                    if (req.valid && req.ready) begin
                        if (!q.mode) begin
                            r_odata  <= '{q.cell_x, q.cell_y, q.cell_z, q.block_value,
                                          1'b0, 1'b1, 1'b0};
                            r_ovalid <= 1'b1;
                        end else begin
                            r_s[0] <= q.start_x; r_s[1] <= q.start_y; r_s[2] <= q.start_z;
                            r_d[0] <= 17'(q.end_x) - 17'(q.start_x);
                            r_d[1] <= 17'(q.end_y) - 17'(q.start_y);
                            r_d[2] <= 17'(q.end_z) - 17'(q.start_z);
                            r_cell[0] <= 12'(trunc_cell(q.start_x));
                            r_cell[1] <= 12'(trunc_cell(q.start_y));
                            r_cell[2] <= 12'(trunc_cell(q.start_z));
                            r_endc[0] <= 12'(trunc_cell(q.end_x));
                            r_endc[1] <= 12'(trunc_cell(q.end_y));
                            r_endc[2] <= 12'(trunc_cell(q.end_z));
                            r_dist2 <= '0;
                            r_ax    <= 2'd0;
                            r_bit   <= 5'd24;
                            r_rem   <= '0;
                            r_quo   <= '0;
                            r_steps <= '0;
                            r_hits  <= '0;
                            r_capped <= 1'b0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    // one quotient bit of 2^24 / mag per cycle
                    if (mag == '0) begin
                        r_td[r_ax] <= T_ALL_ONES;
                        r_tm[r_ax] <= T_ALL_ONES;
                        r_state <= S_TMUL;
                        r_prod  <= '0;
                    end else begin
                        if (rem_try >= {1'b0, mag}) begin
                            r_rem <= 17'(rem_try - {1'b0, mag});
                            r_quo <= {r_quo[23:0], 1'b1};
                        end else begin
                            r_rem <= rem_try[16:0];
                            r_quo <= {r_quo[23:0], 1'b0};
                        end
                        r_bit <= r_bit - 1'b1;
                        if (r_bit == '0) begin
                            r_state <= S_TMAX;
                        end
                    end
                end
                S_TMAX: begin
                    r_td[r_ax] <= r_quo[24] ? T_ALL_ONES : r_quo[23:0];
                    r_prod <= (f_dist <= 0) ? '0 :
                              41'(f_dist[16:0]) * 41'(r_quo[24] ? T_ALL_ONES : r_quo[23:0]);
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    if (mag != '0) begin
                        r_tm[r_ax] <= (r_prod[40:33] != '0 || sat_t[24]) ? T_ALL_ONES
                                                                         : sat_t[23:0];
                    end
                    r_dist2 <= r_dist2 + 36'($signed(dcur) * $signed(dcur));
                    if (r_ax == 2'd2) begin
                        r_state <= S_CHK;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_bit   <= 5'd24;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_CHK: begin
                    if ({k1sq, 16'h0} > 50'(dist9)) begin
                        r_state <= S_TERM;
                    end else if (in_grid) begin
                        r_state <= S_RD;
                    end else begin
                        r_state <= at_end ? S_TERM : S_STEP;
                    end
                end
                S_RD: r_state <= S_VIS;
                S_VIS: begin
                    if (r_rd > r_air) begin
                        if (!r_ovalid) begin
                            r_odata  <= '{r_cell[0][3:0], r_cell[1][3:0], r_cell[2][3:0],
                                          r_rd, 1'b1, 1'b0, 1'b0};
                            r_ovalid <= 1'b1;
                            r_hits   <= r_hits + 1'b1;
                            if (32'(r_hits) + 1 >= MAX_HITS) begin
                                r_capped <= 1'b1;
                                r_state  <= S_TERM;
                            end else begin
                                r_state <= at_end ? S_TERM : S_STEP;
                            end
                        end
                    end else begin
                        r_state <= at_end ? S_TERM : S_STEP;
                    end
                end
                S_STEP: begin
                    r_cell[sel_ax] <= r_d[sel_ax] > 0 ? r_cell[sel_ax] + 12'sd1
                                                      : r_cell[sel_ax] - 12'sd1;
                    r_tm[sel_ax] <= tm_sum[24] ? T_ALL_ONES : tm_sum[23:0];
                    r_steps <= r_steps + 1'b1;
                    r_state <= S_CHK;
                end
                S_TERM: begin
                    if (!r_ovalid) begin
                        r_odata  <= '{4'd0, 4'd0, 4'd0, 8'd0, 1'b0, 1'b1, r_capped};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/vrt_checker.sv =====
module vrt_props import vrt_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input t_rsp rsp_data
);
    // hit words never close a sequence
    a_hit_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_data.hit_valid |-> !rsp_data.last) else $error("hit marked last");
    // capped only on a terminator
    a_cap_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_data.hits_capped |-> rsp_data.last && !rsp_data.hit_valid)
        else $error("capped outside terminator");
    // no new word taken while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready) else $error("input taken with pending word");
    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("word dropped");
endmodule

bind voxel_ray_traversal vrt_props u_vrt_props (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// ===== tb/vrt_checker.sv =====
`timescale 1ns / 1ps

module vrt_checker import vrt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    vrt_req_if         req,
    vrt_rsp_if         rsp,
    output int         o_errors,
    output int         o_pending,
    output int         o_hits,
    output int         o_rays
);
    logic [7:0] voxels [DEPTH];
    logic [7:0] air_level;
    t_rsp       expected_words [$];

    assign o_pending = expected_words.size();

    function automatic int to_cell(int q);
        return (q >= 0) ? (q >>> 8) : -((-q) >>> 8);
    endfunction

    function automatic bit on_grid(int x, int y, int z);
        return x >= 0 && y >= 0 && z >= 0 && x < GRID_SIDE && y < GRID_HEIGHT && z < GRID_SIDE;
    endfunction

    // walk the ray cell by cell and queue the hit words plus the closing word
    function automatic void trace_ray(t_req r);
        int          s [3];
        int          e [3];
        int          d [3];
        int          cur [3];
        int          fin [3];
        int          dir [3];
        int unsigned tmax [3];
        int unsigned tdel [3];
        int          f;
        int          ax;
        int          hits;
        longint      len2;
        longint      td;
        longint      t;
        longint      k1;
        bit          capped;
        t_rsp        w;
        s = '{int'(r.start_x), int'(r.start_y), int'(r.start_z)};
        e = '{int'(r.end_x), int'(r.end_y), int'(r.end_z)};
        len2 = 0;
        for (int a = 0; a < 3; a++) begin
            d[a] = e[a] - s[a];
            cur[a] = to_cell(s[a]);
            fin[a] = to_cell(e[a]);
            dir[a] = d[a] > 0 ? 1 : -1;
            len2 += longint'(d[a]) * longint'(d[a]);
            if (d[a] == 0) begin
                tdel[a] = 32'(T_ALL_ONES);
                tmax[a] = 32'(T_ALL_ONES);
            end else begin
                td = (longint'(1) << 24) / longint'(d[a] < 0 ? -d[a] : d[a]);
                if (td > T_ALL_ONES) td = T_ALL_ONES;
                tdel[a] = 32'(td);
                f = (dir[a] > 0) ? (cur[a] + 1) * 256 - s[a] : s[a] - cur[a] * 256;
                if (f <= 0) begin
                    tmax[a] = 0;
                end else begin
                    t = (longint'(f) * td) >>> 8;
                    tmax[a] = (t > T_ALL_ONES) ? 32'(T_ALL_ONES) : 32'(t);
                end
            end
        end
        hits = 0;
        capped = 0;
        k1 = 1;
        forever begin
            if (k1 * k1 * 65536 > 9 * len2) break;
            if (on_grid(cur[0], cur[1], cur[2])) begin
                w = '0;
                w.hit_x = 4'(cur[0]);
                w.hit_y = 4'(cur[1]);
                w.hit_z = 4'(cur[2]);
                w.block_code = voxels[((cur[1] * GRID_SIDE + cur[2]) * GRID_SIDE) + cur[0]];
                if (w.block_code > air_level) begin
                    w.hit_valid = 1'b1;
                    expected_words.push_back(w);
                    hits++;
                    if (hits >= MAX_HITS) begin
                        capped = 1;
                        break;
                    end
                end
            end
            if (cur[0] == fin[0] && cur[1] == fin[1] && cur[2] == fin[2]) break;
            if (tmax[0] < tmax[1] && tmax[0] < tmax[2]) ax = 0;
            else if (tmax[1] < tmax[2]) ax = 1;
            else ax = 2;
            cur[ax] += dir[ax];
            tmax[ax] = (tmax[ax] + tdel[ax] > T_ALL_ONES) ? 32'(T_ALL_ONES)
                                                           : tmax[ax] + tdel[ax];
            k1++;
        end
        w = '0;
        w.last = 1'b1;
        w.hits_capped = capped;
        expected_words.push_back(w);
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            o_errors++;
        end
    endfunction

    initial begin
        o_errors = 0;
        o_hits = 0;
        o_rays = 0;
        air_level = '0;
    end

    always @(posedge i_clk) begin
        t_rsp w;
        if (!i_rst_n) begin
            foreach (voxels[i]) voxels[i] = '0;
            air_level = '0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) air_level = i_cfg_wdata;
            if (req.valid && req.ready) begin
                if (req.data.mode == 1'b0) begin
                    voxels[((req.data.cell_y * GRID_SIDE + req.data.cell_z) * GRID_SIDE)
                           + req.data.cell_x] = req.data.block_value;
                    w = '0;
                    w.hit_x = req.data.cell_x;
                    w.hit_y = req.data.cell_y;
                    w.hit_z = req.data.cell_z;
                    w.block_code = req.data.block_value;
                    w.last = 1'b1;
                    expected_words.push_back(w);
                end else begin
                    o_rays++;
                    trace_ray(req.data);
                end
            end
            if (rsp.valid && rsp.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %p", $time, rsp.data);
                    o_errors++;
                end else begin
                    w = expected_words.pop_front();
                    if (rsp.data.hit_valid) o_hits++;
                    check_field("hit_x", w.hit_x, rsp.data.hit_x);
                    check_field("hit_y", w.hit_y, rsp.data.hit_y);
                    check_field("hit_z", w.hit_z, rsp.data.hit_z);
                    check_field("block_code", w.block_code, rsp.data.block_code);
                    check_field("hit_valid", w.hit_valid, rsp.data.hit_valid);
                    check_field("last", w.last, rsp.data.last);
                    check_field("hits_capped", w.hits_capped, rsp.data.hits_capped);
                end
            end
        end
    end
endmodule

// ===== tb/voxel_ray_traversal_test.sv =====
`timescale 1ns / 1ps

module voxel_ray_traversal_test;
    import vrt_pkg::*;

    localparam int STALL_LIMIT = 30000;   // clearing pass, longest ray and the long hold all fit

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;
    int         errors;
    int         pending;
    int         hits_seen;
    int         rays_sent;
    int         words_sent;
    int         quiet_cycles;
    bit         calm;        // no idling on either side
    bit         hold_rsp;    // long receiver hold-off

    vrt_req_if req_ch ();
    vrt_rsp_if rsp_ch ();

    voxel_ray_traversal dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .req        (req_ch),
        .rsp        (rsp_ch)
    );

    vrt_checker checker_inst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_hits     (hits_seen),
        .o_rays     (rays_sent)
    );

    // 20 ns clock, first rising edge at 10 ns
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // receiver: random stalls, none in the calm stretch, ready held low throughout the hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_rsp) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= 15);
        end
    end

    // hold the receiver long enough that the block must stall its input
    initial begin
        hold_rsp = 1'b0;
        wait (words_sent >= 80);
        @(posedge i_clk);
        hold_rsp <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_rsp <= 1'b0;
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(t_req w);
        req_ch.valid <= 1'b1;
        req_ch.data <= w;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        words_sent++;
        if (!calm && $urandom_range(99) < 15) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic put_cell(int x, int y, int z, int v);
        t_req w;
        w = '0;
        w.mode = 1'b0;
        w.cell_x = 4'(x);
        w.cell_y = 4'(y);
        w.cell_z = 4'(z);
        w.block_value = 8'(v);
        w.start_x = 16'($urandom);     // ignored fields still get toggled
        w.end_z = 16'($urandom);
        send_word(w);
    endtask

    task automatic cast(int sx, int sy, int sz, int ex, int ey, int ez);
        t_req w;
        w = '0;
        w.mode = 1'b1;
        w.start_x = 16'(sx);
        w.start_y = 16'(sy);
        w.start_z = 16'(sz);
        w.end_x = 16'(ex);
        w.end_y = 16'(ey);
        w.end_z = 16'(ez);
        w.cell_x = 4'($urandom);
        w.cell_y = 4'($urandom);
        w.cell_z = 4'($urandom);
        w.block_value = 8'($urandom);
        send_word(w);
    endtask

    // drain everything, then write air_code while the block is idle
    task automatic set_air(int v);
        @(posedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 8'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int near_coord();
        return $urandom_range(20 * 256) - 2 * 256;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        calm = 1'b0;
        words_sent = 0;
        quiet_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: a few solid cells and rays through them
        put_cell(0, 0, 0, 255);
        put_cell(15, 15, 15, 1);
        put_cell(5, 5, 5, 0);
        put_cell(6, 5, 5, 200);
        put_cell(3, 0, 0, 7);
        cast(128, 128, 128, 15 * 256 + 128, 15 * 256 + 128, 15 * 256 + 128);   // main diagonal
        cast(128, 128, 128, 128, 128, 128);                                     // zero length
        cast(5 * 256, 5 * 256 + 64, 5 * 256 + 64, 9 * 256, 5 * 256 + 64, 5 * 256 + 64);
        cast(-384, 64, 64, 4 * 256, 64, 64);               // negative start truncates toward zero
        cast(15 * 256 + 200, 15 * 256 + 200, 15 * 256 + 200, 0, 0, 0);        // backward
        cast(-32768, -32768, -32768, 32767, 32767, 32767);  // field extremes
        cast(32767, -32768, 0, -32768, 32767, 0);
        cast(256, 256, 256, 256, 256, 256 * 14);             // two axes with no motion
        set_air(255);
        cast(128, 128, 128, 15 * 256 + 128, 15 * 256 + 128, 15 * 256 + 128);  // all air now
        set_air(6);
        cast(128, 64, 64, 10 * 256, 64, 64);
        put_cell(2, 3, 4, 9);

        // random: writes mostly packed into the middle so rays find solid cells
        for (int i = 0; i < 440; i++) begin
            if (i == 150) set_air($urandom_range(255));
            if (i == 300) set_air(0);
            if (i == 330) begin
                set_air(255);
                set_air(0);
            end
            calm = (i >= 200 && i < 260);
            if ($urandom_range(99) < 35) begin
                if ($urandom_range(1))
                    put_cell($urandom_range(4, 11), $urandom_range(4, 11),
                             $urandom_range(4, 11), $urandom_range(255));
                else
                    put_cell($urandom_range(15), $urandom_range(15), $urandom_range(15),
                             $urandom_range(255));
            end else if ($urandom_range(99) < 10) begin
                cast($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                cast(near_coord(), near_coord(), near_coord(),
                     near_coord(), near_coord(), near_coord());
            end
        end

        @(posedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("sent %0d words, %0d of them rays, and saw %0d hit words", words_sent,
                 rays_sent, hits_seen);
        $display("air_code swept through 0, 255 and random levels under random stalls");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
